>>> rtl/bco_pkg.sv
// shared coordinate width for the box/capsule overlap test
package bco_pkg;
   localparam int unsigned CoordBits = 8;
endpackage

>>> rtl/bco_if.sv
// valid/ready channel interface with a generic payload
interface bco_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> rtl/bco_geo.sv
// stage one: distances, extents and capsule geometry
module bco_geo #(
   parameter int unsigned W = 8
) (
   input  logic         clock,
   input  logic         advance,
   input  logic         a_kind,
   input  logic [W-1:0] a_x,
   input  logic [W-1:0] a_y,
   input  logic [W-1:0] a_ex,
   input  logic [W-1:0] a_ey,
   input  logic         b_kind,
   input  logic [W-1:0] b_x,
   input  logic [W-1:0] b_y,
   input  logic [W-1:0] b_ex,
   input  logic [W-1:0] b_ey,
   output logic         reject_ff,
   output logic         both_box_ff,
   output logic         both_cap_ff,
   // circle pair deltas (signed) and radius
   output logic signed [W+2:0] ddx_ff [4],
   output logic signed [W+2:0] ddy_ff [4],
   output logic [W:0]          rad_ff,
   output logic                core_ff
);
   localparam int S = W + 3;
   logic signed [S-1:0] ax, ay, bx, by, dxs, dys;
   logic [W:0] dx, dy;
   logic [W+1:0] wa, ha, wb, hb;
   logic [W-1:0] ra, rb, oxa, oya, oxb, oyb;
   logic [W:0] iwa, iha, iwb, ihb;
   logic signed [S-1:0] ddx_in [4], ddy_in [4];
   logic [W:0] rad_in;
   logic core_in, reject_in;
   // box/capsule selection
   logic         cap_is_a;
   logic signed [S-1:0] bcx, bcy, ccx, ccy, lft, rgt, top, bot, ox, oy, cx, cy;
   logic [W-1:0] bex, bey, cr;
   logic [W:0] ciw, cih;
   always_comb begin
      cx = '0; cy = '0;
      ax = S'(a_x); ay = S'(a_y); bx = S'(b_x); by = S'(b_y);
      dxs = ax - bx; dys = ay - by;
      dx = dxs[S-1] ? (W+1)'(-dxs) : (W+1)'(dxs);
      dy = dys[S-1] ? (W+1)'(-dys) : (W+1)'(dys);
      wa = a_kind ? {1'b0, a_ex, 1'b0} : (W+2)'(a_ex);
      ha = a_kind ? {1'b0, a_ey, 1'b0} : (W+2)'(a_ey);
      wb = b_kind ? {1'b0, b_ex, 1'b0} : (W+2)'(b_ex);
      hb = b_kind ? {1'b0, b_ey, 1'b0} : (W+2)'(b_ey);
      reject_in = ({1'b0, dx, 1'b0} >= {1'b0, wa} + {1'b0, wb})
         || ({1'b0, dy, 1'b0} >= {1'b0, ha} + {1'b0, hb});
      if (a_ey > a_ex) begin
         ra = a_ex; oxa = '0; oya = a_ey - a_ex;
      end else begin
         ra = a_ey; oxa = a_ex - a_ey; oya = '0;
      end
      if (b_ey > b_ex) begin
         rb = b_ex; oxb = '0; oyb = b_ey - b_ex;
      end else begin
         rb = b_ey; oxb = b_ex - b_ey; oyb = '0;
      end
      iwa = a_ey > a_ex ? {a_ex, 1'b0} : {oxa, 1'b0};
      iha = a_ey > a_ex ? {oya, 1'b0} : {a_ey, 1'b0};
      iwb = b_ey > b_ex ? {b_ex, 1'b0} : {oxb, 1'b0};
      ihb = b_ey > b_ex ? {oyb, 1'b0} : {b_ey, 1'b0};
      cap_is_a = a_kind;
      bcx = cap_is_a ? bx : ax; bcy = cap_is_a ? by : ay;
      ccx = cap_is_a ? ax : bx; ccy = cap_is_a ? ay : by;
      bex = cap_is_a ? b_ex : a_ex; bey = cap_is_a ? b_ey : a_ey;
      cr = cap_is_a ? ra : rb;
      ox = S'(cap_is_a ? oxa : oxb); oy = S'(cap_is_a ? oya : oyb);
      ciw = cap_is_a ? iwa : iwb; cih = cap_is_a ? iha : ihb;
      lft = bcx - S'(bex >> 1); rgt = bcx + S'(bex >> 1);
      top = bcy - S'(bey >> 1); bot = bcy + S'(bey >> 1);
      if (a_kind && b_kind) begin
         rad_in = (W+1)'(ra) + (W+1)'(rb);
         for (int k = 0; k < 4; k++) begin
            ddx_in[k] = (ax + ((k & 2) != 0 ? S'(oxa) : -S'(oxa)))
                      - (bx + ((k & 1) != 0 ? S'(oxb) : -S'(oxb)));
            ddy_in[k] = (ay + ((k & 2) != 0 ? S'(oya) : -S'(oya)))
                      - (by + ((k & 1) != 0 ? S'(oyb) : -S'(oyb)));
         end
         core_in = ({1'b0, dx, 1'b0} < (W+2)'(iwa) + (W+2)'(iwb))
                && ({1'b0, dy, 1'b0} < (W+2)'(iha) + (W+2)'(ihb));
      end else begin
         rad_in = (W+1)'(cr);
         for (int k = 0; k < 4; k++) begin
            cx = ccx + ((k & 1) != 0 ? ox : -ox);
            cy = ccy + ((k & 1) != 0 ? oy : -oy);
            ddx_in[k] = cx < lft ? cx - lft : (cx > rgt ? cx - rgt : '0);
            ddy_in[k] = cy < top ? cy - top : (cy > bot ? cy - bot : '0);
         end
         core_in = ({1'b0, dx, 1'b0} < (W+2)'(bex) + (W+2)'(ciw))
                && ({1'b0, dy, 1'b0} < (W+2)'(bey) + (W+2)'(cih));
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         reject_ff   <= reject_in;
         both_box_ff <= !a_kind && !b_kind;
         both_cap_ff <= a_kind && b_kind;
         ddx_ff      <= ddx_in;
         ddy_ff      <= ddy_in;
         rad_ff      <= rad_in;
         core_ff     <= core_in;
      end
   end
endmodule

>>> rtl/bco_dist.sv
// stages two and three: squares, then sums and the final decision
module bco_dist #(
   parameter int unsigned W = 8
) (
   input  logic                clock,
   input  logic                advance2,
   input  logic                advance3,
   input  logic                reject,
   input  logic                both_box,
   input  logic                both_cap,
   input  logic signed [W+2:0] ddx [4],
   input  logic signed [W+2:0] ddy [4],
   input  logic [W:0]          rad,
   input  logic                core,
   output logic                hit_ff
);
   localparam int Q = 2 * (W + 2);
   logic [Q-1:0] sx_ff [4], sy_ff [4], rs_ff;
   logic reject_ff, box_ff, cap_ff, core_ff;
   logic circ;
   always_ff @(posedge clock) begin
      if (advance2) begin
         for (int k = 0; k < 4; k++) begin
            sx_ff[k] <= $unsigned(Q'(ddx[k]) * Q'(ddx[k]));
            sy_ff[k] <= $unsigned(Q'(ddy[k]) * Q'(ddy[k]));
         end
         rs_ff     <= Q'(rad) * Q'(rad);
         reject_ff <= reject;
         box_ff    <= both_box;
         cap_ff    <= both_cap;
         core_ff   <= core;
      end
   end
   always_comb begin
      circ = 1'b0;
      for (int k = 0; k < 4; k++) begin
         if ((cap_ff || k == 0 || k == 1)
             && ((Q+1)'(sx_ff[k]) + (Q+1)'(sy_ff[k]) < (Q+1)'(rs_ff)))
            circ = 1'b1;
      end
   end
   always_ff @(posedge clock) begin
      if (advance3) hit_ff <= !reject_ff && (box_ff || circ || core_ff);
   end
endmodule

>>> rtl/box_capsule_overlap_test.sv
// top level of the box/capsule overlap test
// an accepted req beat passes the geo, square and decision registers to the rsp beat
// throughput: one beat per cycle while rsp is not stalled, three pipeline registers with valid bits
// a stalled rsp holds the pipeline, nothing lost or repeated
// reset clears the valid bits only, payload registers are not reset
module box_capsule_overlap_test
   import bco_pkg::*;
#(
   parameter int unsigned COORD_BITS = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_a_kind,
   input  logic [COORD_BITS-1:0] req_a_x,
   input  logic [COORD_BITS-1:0] req_a_y,
   input  logic [COORD_BITS-1:0] req_a_extent_x,
   input  logic [COORD_BITS-1:0] req_a_extent_y,
   input  logic req_b_kind,
   input  logic [COORD_BITS-1:0] req_b_x,
   input  logic [COORD_BITS-1:0] req_b_y,
   input  logic [COORD_BITS-1:0] req_b_extent_x,
   input  logic [COORD_BITS-1:0] req_b_extent_y,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_hit
);
   localparam int W = COORD_BITS;
   logic v1_ff, v2_ff, v3_ff, v1_in, v2_in, v3_in;
   logic adv1, adv2, adv3;
   logic reject, both_box, both_cap, core;
   logic signed [W+2:0] ddx [4], ddy [4];
   logic [W:0] rad;

   assign adv3 = !v3_ff || rsp_ready;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_ready = adv1;
   assign v1_in = adv1 ? req_valid : v1_ff;
   assign v2_in = adv2 ? v1_ff : v2_ff;
   assign v3_in = adv3 ? v2_ff : v3_ff;
   assign rsp_valid = v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   bco_geo #(.W(W)) u_geo (
      .clock(clock), .advance(adv1 && req_valid),
      .a_kind(req_a_kind), .a_x(req_a_x), .a_y(req_a_y),
      .a_ex(req_a_extent_x), .a_ey(req_a_extent_y),
      .b_kind(req_b_kind), .b_x(req_b_x), .b_y(req_b_y),
      .b_ex(req_b_extent_x), .b_ey(req_b_extent_y),
      .reject_ff(reject), .both_box_ff(both_box), .both_cap_ff(both_cap),
      .ddx_ff(ddx), .ddy_ff(ddy), .rad_ff(rad), .core_ff(core)
   );

   bco_dist #(.W(W)) u_dist (
      .clock(clock), .advance2(adv2 && v1_ff), .advance3(adv3 && v2_ff),
      .reject(reject), .both_box(both_box), .both_cap(both_cap),
      .ddx(ddx), .ddy(ddy), .rad(rad), .core(core), .hit_ff(rsp_hit)
   );

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit))
      else $error("rsp changed while stalled");
   a_fill: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> v1_ff)
      else $error("accepted beat lost");
   a_move: assert property (@(posedge clock) disable iff (reset)
      v2_ff && adv3 |=> v3_ff)
      else $error("stage three dropped a beat");
endmodule

>>> tb/tb_top.sv
// self-checking testbench for the box/capsule overlap test
module tb_top;
   import bco_pkg::*;

   typedef struct packed {
      logic                 a_kind;
      logic [CoordBits-1:0] a_x;
      logic [CoordBits-1:0] a_y;
      logic [CoordBits-1:0] a_extent_x;
      logic [CoordBits-1:0] a_extent_y;
      logic                 b_kind;
      logic [CoordBits-1:0] b_x;
      logic [CoordBits-1:0] b_y;
      logic [CoordBits-1:0] b_extent_x;
      logic [CoordBits-1:0] b_extent_y;
   } pair_type;

   typedef struct {
      int r, ox, oy, iw, ih;
   } capsule_type;

   localparam int NumRandom = 1500;
   localparam int CycleLimit = 200000;

   class overlap_scoreboard;
      bit hit_queue[$];
      int failures;

      function capsule_type capsule_of(int ex, int ey);
         capsule_type g;
         if (ey > ex) begin
            g.r = ex; g.ox = 0; g.oy = ey - ex; g.iw = ex * 2; g.ih = g.oy * 2;
         end else begin
            g.r = ey; g.ox = ex - ey; g.oy = 0; g.iw = g.ox * 2; g.ih = ey * 2;
         end
         return g;
      endfunction

      function int clamp(int v, int lo, int hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      function bit overlaps(pair_type p);
         int ax, ay, aex, aey, bx, by, bex, bey;
         int wa, ha, wb, hb, dx, dy, rs, ddx, ddy, cx, cy;
         int bxx, bxy, bxex, bxey, cpx, cpy, cpex, cpey;
         capsule_type g1, g2;
         ax = p.a_x; ay = p.a_y; aex = p.a_extent_x; aey = p.a_extent_y;
         bx = p.b_x; by = p.b_y; bex = p.b_extent_x; bey = p.b_extent_y;
         wa = p.a_kind ? aex * 2 : aex;
         ha = p.a_kind ? aey * 2 : aey;
         wb = p.b_kind ? bex * 2 : bex;
         hb = p.b_kind ? bey * 2 : bey;
         dx = ax > bx ? ax - bx : bx - ax;
         dy = ay > by ? ay - by : by - ay;
         if (dx * 2 >= wa + wb || dy * 2 >= ha + hb) return 1'b0;
         if (!p.a_kind && !p.b_kind) return 1'b1;
         if (p.a_kind && p.b_kind) begin
            g1 = capsule_of(aex, aey);
            g2 = capsule_of(bex, bey);
            rs = (g1.r + g2.r) * (g1.r + g2.r);
            for (int i = -1; i <= 1; i += 2)
               for (int j = -1; j <= 1; j += 2) begin
                  ddx = (ax + g1.ox * i) - (bx + g2.ox * j);
                  ddy = (ay + g1.oy * i) - (by + g2.oy * j);
                  if (ddx * ddx + ddy * ddy < rs) return 1'b1;
               end
            return dx * 2 < g1.iw + g2.iw && dy * 2 < g1.ih + g2.ih;
         end
         if (p.a_kind) begin
            bxx = bx; bxy = by; bxex = bex; bxey = bey;
            cpx = ax; cpy = ay; cpex = aex; cpey = aey;
         end else begin
            bxx = ax; bxy = ay; bxex = aex; bxey = aey;
            cpx = bx; cpy = by; cpex = bex; cpey = bey;
         end
         g1 = capsule_of(cpex, cpey);
         for (int i = -1; i <= 1; i += 2) begin
            cx = cpx + g1.ox * i;
            cy = cpy + g1.oy * i;
            ddx = cx - clamp(cx, bxx - bxex / 2, bxx + bxex / 2);
            ddy = cy - clamp(cy, bxy - bxey / 2, bxy + bxey / 2);
            if (ddx * ddx + ddy * ddy < g1.r * g1.r) return 1'b1;
         end
         return dx * 2 < bxex + g1.iw && dy * 2 < bxey + g1.ih;
      endfunction

      function void note_pair(pair_type p);
         hit_queue.push_back(overlaps(p));
      endfunction

      function void check_hit(bit hit);
         bit want;
         if (hit_queue.size() == 0) begin
            $error("unexpected rsp beat, hit %0d", hit);
            failures++;
            return;
         end
         want = hit_queue.pop_front();
         if (want !== hit) begin
            $error("hit mismatch: expected %0d actual %0d", want, hit);
            failures++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycles = 0;
   bit   quiet = 1'b0;
   overlap_scoreboard sb = new();

   bco_if #(.payload_type(pair_type)) req_ch ();
   bco_if rsp_ch ();

   always #5 clock = ~clock;

   box_capsule_overlap_test dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_ch.valid),
      .req_ready      (req_ch.ready),
      .req_a_kind     (req_ch.data.a_kind),
      .req_a_x        (req_ch.data.a_x),
      .req_a_y        (req_ch.data.a_y),
      .req_a_extent_x (req_ch.data.a_extent_x),
      .req_a_extent_y (req_ch.data.a_extent_y),
      .req_b_kind     (req_ch.data.b_kind),
      .req_b_x        (req_ch.data.b_x),
      .req_b_y        (req_ch.data.b_y),
      .req_b_extent_x (req_ch.data.b_extent_x),
      .req_b_extent_y (req_ch.data.b_extent_y),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_hit        (rsp_ch.data)
   );

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= quiet || $urandom_range(99) >= 7;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) sb.note_pair(req_ch.data);
      if (!reset && rsp_ch.valid && rsp_ch.ready) sb.check_hit(rsp_ch.data);
   end

   task automatic send_pair(pair_type p);
      while (!quiet && $urandom_range(99) < 7) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= p;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   function automatic pair_type make_pair(bit ak, int ax, int ay, int aex, int aey,
                                          bit bk, int bx, int by, int bex, int bey);
      pair_type p;
      p.a_kind = ak;
      p.a_x = CoordBits'(ax);
      p.a_y = CoordBits'(ay);
      p.a_extent_x = CoordBits'(aex);
      p.a_extent_y = CoordBits'(aey);
      p.b_kind = bk;
      p.b_x = CoordBits'(bx);
      p.b_y = CoordBits'(by);
      p.b_extent_x = CoordBits'(bex);
      p.b_extent_y = CoordBits'(bey);
      return p;
   endfunction

   function automatic int near_coord(int c);
      int v;
      v = c + int'($urandom_range(80)) - 40;
      return v < 0 ? 0 : (v > 255 ? 255 : v);
   endfunction

   function automatic int rand_extent();
      return $urandom_range(9) == 0 ? int'($urandom_range(255)) : int'($urandom_range(60));
   endfunction

   initial begin
      pair_type p;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed corners
      send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_pair(make_pair(1, 0, 0, 0, 0, 1, 0, 0, 0, 0));
      send_pair(make_pair(0, 255, 255, 255, 255, 0, 0, 0, 255, 255));
      send_pair(make_pair(1, 255, 255, 255, 255, 1, 0, 0, 255, 255));
      send_pair(make_pair(0, 255, 0, 255, 255, 1, 0, 255, 255, 255));
      send_pair(make_pair(1, 0, 255, 255, 255, 0, 255, 0, 255, 255));
      // touching boxes and capsules do not hit, overlapping by one they do
      send_pair(make_pair(0, 100, 100, 10, 10, 0, 110, 100, 10, 10));
      send_pair(make_pair(0, 100, 100, 10, 10, 0, 109, 100, 10, 10));
      send_pair(make_pair(1, 100, 100, 5, 5, 1, 110, 100, 5, 5));
      send_pair(make_pair(1, 100, 100, 5, 5, 1, 109, 100, 5, 5));
      // equal radii circles on a diagonal
      send_pair(make_pair(1, 100, 100, 10, 10, 1, 114, 114, 10, 10));
      send_pair(make_pair(1, 100, 100, 10, 10, 1, 115, 115, 10, 10));
      // odd box size against a capsule
      send_pair(make_pair(0, 100, 100, 11, 7, 1, 110, 100, 5, 5));
      send_pair(make_pair(1, 90, 100, 5, 5, 0, 100, 100, 11, 7));
      send_pair(make_pair(0, 100, 100, 9, 9, 1, 108, 108, 4, 4));
      // elongated capsules, corner of box near circle
      send_pair(make_pair(1, 50, 50, 30, 5, 1, 80, 62, 5, 30));
      send_pair(make_pair(1, 50, 50, 5, 30, 0, 60, 80, 10, 10));
      send_pair(make_pair(0, 50, 50, 20, 20, 1, 70, 70, 12, 12));
      // zero extent on one side
      send_pair(make_pair(0, 100, 100, 0, 0, 0, 100, 100, 50, 50));
      send_pair(make_pair(1, 100, 100, 0, 30, 1, 100, 100, 30, 0));
      send_pair(make_pair(0, 100, 100, 20, 20, 1, 100, 100, 0, 0));
      for (int n = 0; n < NumRandom; n++) begin
         quiet = n >= 600 && n < 900;
         p.a_kind = 1'($urandom_range(1));
         p.b_kind = 1'($urandom_range(1));
         p.a_x = CoordBits'($urandom_range(255));
         p.a_y = CoordBits'($urandom_range(255));
         p.a_extent_x = CoordBits'(rand_extent());
         p.a_extent_y = CoordBits'(rand_extent());
         p.b_extent_x = CoordBits'(rand_extent());
         p.b_extent_y = CoordBits'(rand_extent());
         if ($urandom_range(3) == 0) begin
            p.b_x = CoordBits'($urandom_range(255));
            p.b_y = CoordBits'($urandom_range(255));
         end else begin
            p.b_x = CoordBits'(near_coord(p.a_x));
            p.b_y = CoordBits'(near_coord(p.a_y));
         end
         send_pair(p);
      end
      quiet = 1'b0;
      req_ch.valid <= 1'b0;
      while (sb.hit_queue.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.failures == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end
endmodule
